// ===== hdl/bfd_pkg.sv =====
// ----------------------------------------------------------------------------
// bfd_pkg
// Shared types, constants and helpers of the box filter downscaler.
// ----------------------------------------------------------------------------
package bfd_pkg;

    // Default sizes
    localparam int MAX_DST_WIDTH = 1024;
    localparam int MAX_SCALE     = 16;
    localparam int MAX_SRC_DIM   = 4096;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // Register widths
    localparam int SRC_DIM_W = 13;
    localparam int DST_DIM_W = 11;
    localparam int SCALE_W   = 5;

    // Largest output row count the height register can express
    localparam int DST_HEIGHT_MAX = 2047;

    localparam int PIX_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_WIDTH  = 3'd0,
        CFG_SRC_HEIGHT = 3'd1,
        CFG_DST_WIDTH  = 3'd2,
        CFG_DST_HEIGHT = 3'd3,
        CFG_H_SCALE    = 3'd4,
        CFG_W_SCALE    = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACC,
        ST_DIV,
        ST_OUT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic acc;
        logic div_start;
        logic div_step;
        logic out_load;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic active;
        logic blk_done;
        logic div_last;
        logic out_free;
    } t_sts;

    // Zero acts as one, values above hi act as hi
    function automatic logic [31:0] clamp_reg(input logic [31:0] v, input logic [31:0] hi);
        logic [31:0] r;
        if (v == 32'd0) begin
            r = 32'd1;
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== hdl/bfd_div.sv =====
// ----------------------------------------------------------------------------
// bfd_div
// Four-lane restoring divider, one quotient bit per lane per cycle while i_step is high.
// ----------------------------------------------------------------------------
module bfd_div #(
    parameter int SUMW = 16,
    parameter int NPW  = 9
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_step,
    input  logic [4*SUMW-1:0] i_dividend,
    input  logic [NPW-1:0]    i_divisor,
    output logic [31:0]       o_quot,    // red, green, blue, alpha from bit 0
    output logic              o_last
);

    localparam int CNW = $clog2(SUMW);

    logic [SUMW-1:0] r_q   [4];
    logic [NPW-1:0]  r_rem [4];
    logic [SUMW-1:0] n_q   [4];
    logic [NPW-1:0]  n_rem [4];
    logic [CNW-1:0]  r_cnt;

    // One shift-subtract step per lane
    always_comb begin
        logic [NPW:0] sh;
        logic [NPW:0] df;
        for (int c = 0; c < 4; c++) begin
            sh = {r_rem[c], r_q[c][SUMW-1]};
            df = sh - {1'b0, i_divisor};
            if (sh >= {1'b0, i_divisor}) begin
                n_rem[c] = df[NPW-1:0];
                n_q[c]   = {r_q[c][SUMW-2:0], 1'b1};
            end else begin
                n_rem[c] = sh[NPW-1:0];
                n_q[c]   = {r_q[c][SUMW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 4; c++) begin
            if (i_start) begin
                r_q[c]   <= i_dividend[c*SUMW +: SUMW];
                r_rem[c] <= '0;
            end else if (i_step) begin
                r_q[c]   <= n_q[c];
                r_rem[c] <= n_rem[c];
            end
        end
    end

    // Step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= '0;
        end else if (i_step) begin
            r_cnt <= r_cnt + CNW'(1);
        end
    end

    assign o_last = (r_cnt == CNW'(SUMW - 1));

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            o_quot[c*8 +: 8] = r_q[c][7:0];
        end
    end

endmodule

// ===== hdl/bfd_dpath.sv =====
// ----------------------------------------------------------------------------
// bfd_dpath
// Registers, position counters, column sum memory, divider and output stage.
// ----------------------------------------------------------------------------
module bfd_dpath #(
    parameter int MAX_DST_WIDTH = bfd_pkg::MAX_DST_WIDTH,
    parameter int MAX_SCALE     = bfd_pkg::MAX_SCALE,
    parameter int MAX_SRC_DIM   = bfd_pkg::MAX_SRC_DIM
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  bfd_pkg::t_cmd                    i_cmd,
    output bfd_pkg::t_sts                    o_sts,
    input  logic                             i_cfg_valid,
    input  logic [bfd_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  logic [bfd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [bfd_pkg::PIX_W-1:0]        i_pix,
    input  logic                             i_m_tready,
    output logic                             o_m_tvalid,
    output logic [bfd_pkg::PIX_W-1:0]        o_m_tdata,
    output logic                             o_m_tlast
);

    localparam int SUMW = 8 + $clog2(MAX_SCALE * MAX_SCALE);
    localparam int NPW  = $clog2(MAX_SCALE * MAX_SCALE + 1);
    localparam int AW   = (MAX_DST_WIDTH > 1) ? $clog2(MAX_DST_WIDTH) : 1;
    localparam int CW   = $clog2(MAX_SRC_DIM + 1);
    localparam int OW   = $clog2(MAX_SCALE + 1);

    // Configuration registers
    logic [bfd_pkg::SRC_DIM_W-1:0] r_src_width, r_src_height;
    logic [bfd_pkg::DST_DIM_W-1:0] r_dst_width, r_dst_height;
    logic [bfd_pkg::SCALE_W-1:0]   r_h_scale, r_w_scale;

    // Write to a known register; unknown indexes have no effect
    logic cfg_hit;
    assign cfg_hit = i_cfg_valid && (i_cfg_addr <= bfd_pkg::CFG_W_SCALE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= bfd_pkg::SRC_DIM_W'(1);
            r_src_height <= bfd_pkg::SRC_DIM_W'(1);
            r_dst_width  <= bfd_pkg::DST_DIM_W'(1);
            r_dst_height <= bfd_pkg::DST_DIM_W'(1);
            r_h_scale    <= bfd_pkg::SCALE_W'(1);
            r_w_scale    <= bfd_pkg::SCALE_W'(1);
        end else if (i_cfg_valid) begin
            unique case (bfd_pkg::t_cfg_idx'(i_cfg_addr))
                bfd_pkg::CFG_SRC_WIDTH:  r_src_width  <= i_cfg_data[bfd_pkg::SRC_DIM_W-1:0];
                bfd_pkg::CFG_SRC_HEIGHT: r_src_height <= i_cfg_data[bfd_pkg::SRC_DIM_W-1:0];
                bfd_pkg::CFG_DST_WIDTH:  r_dst_width  <= i_cfg_data[bfd_pkg::DST_DIM_W-1:0];
                bfd_pkg::CFG_DST_HEIGHT: r_dst_height <= i_cfg_data[bfd_pkg::DST_DIM_W-1:0];
                bfd_pkg::CFG_H_SCALE:    r_h_scale    <= i_cfg_data[bfd_pkg::SCALE_W-1:0];
                bfd_pkg::CFG_W_SCALE:    r_w_scale    <= i_cfg_data[bfd_pkg::SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective sizes
    logic [31:0] sw, sh, dw, dh, hs, ws;
    assign sw = bfd_pkg::clamp_reg(32'(r_src_width),  32'(MAX_SRC_DIM));
    assign sh = bfd_pkg::clamp_reg(32'(r_src_height), 32'(MAX_SRC_DIM));
    assign dw = bfd_pkg::clamp_reg(32'(r_dst_width),  32'(MAX_DST_WIDTH));
    assign dh = bfd_pkg::clamp_reg(32'(r_dst_height), 32'(bfd_pkg::DST_HEIGHT_MAX));
    assign hs = bfd_pkg::clamp_reg(32'(r_h_scale),    32'(MAX_SCALE));
    assign ws = bfd_pkg::clamp_reg(32'(r_w_scale),    32'(MAX_SCALE));

    // Position counters
    logic [CW-1:0] r_sc, r_sr, r_oc, r_or;
    logic [OW-1:0] r_bc, r_br;
    logic [CW-1:0] n_sc, n_sr, n_oc, n_or;
    logic [OW-1:0] n_bc, n_br;

    always_comb begin
        logic [31:0] bc, br, oc, orw, sc, sr;
        bc  = 32'(r_bc) + 32'd1;
        br  = 32'(r_br);
        oc  = 32'(r_oc);
        orw = 32'(r_or);
        sc  = 32'(r_sc) + 32'd1;
        sr  = 32'(r_sr);
        if (bc >= ws) begin
            bc = 32'd0;
            oc = oc + 32'd1;
        end
        if (sc >= sw) begin
            sc = 32'd0;
            bc = 32'd0;
            oc = 32'd0;
            br = br + 32'd1;
            if (br >= hs) begin
                br  = 32'd0;
                orw = orw + 32'd1;
            end
            sr = sr + 32'd1;
            if (sr >= sh) begin
                sr = 32'd0; br = 32'd0; orw = 32'd0;
            end
        end
        n_bc = bc[OW-1:0];
        n_br = br[OW-1:0];
        n_oc = oc[CW-1:0];
        n_or = orw[CW-1:0];
        n_sc = sc[CW-1:0];
        n_sr = sr[CW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_hit) begin
            r_sc <= '0; r_sr <= '0; r_oc <= '0; r_or <= '0;
            r_bc <= '0; r_br <= '0;
        end else if (i_cmd.accept) begin
            r_sc <= n_sc; r_sr <= n_sr; r_oc <= n_oc; r_or <= n_or;
            r_bc <= n_bc; r_br <= n_br;
        end
    end

    // Per-pixel flags from the position before the update
    logic active, first, done, flast;
    assign active = (32'(r_oc) < dw) && (32'(r_or) < dh);
    assign first  = (r_bc == '0) && (r_br == '0);
    assign done   = (32'(r_br) + 32'd1 >= hs) && (32'(r_bc) + 32'd1 >= ws);
    assign flast  = (32'(r_or) + 32'd1 == dh) && (32'(r_oc) + 32'd1 == dw);

    logic [bfd_pkg::PIX_W-1:0] r_px;
    logic                      r_first, r_done, r_flast;
    logic [AW-1:0]             r_addr;
    logic [NPW-1:0]            r_npix;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_px    <= i_pix;
            r_first <= first;
            r_done  <= done;
            r_flast <= flast;
            r_addr  <= r_oc[AW-1:0];
            r_npix  <= NPW'(NPW'(hs[OW-1:0]) * NPW'(ws[OW-1:0]));
        end
    end

    // Column sum memory
    logic [4*SUMW-1:0] r_mem [MAX_DST_WIDTH];
    logic [4*SUMW-1:0] r_rd;
    logic [4*SUMW-1:0] n_sum;

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            if (r_first) begin
                n_sum[c*SUMW +: SUMW] = SUMW'(r_px[c*8 +: 8]);
            end else begin
                n_sum[c*SUMW +: SUMW] = r_rd[c*SUMW +: SUMW] + SUMW'(r_px[c*8 +: 8]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rd <= r_mem[r_oc[AW-1:0]];
        end
        if (i_cmd.acc) begin
            r_mem[r_addr] <= n_sum;
        end
    end

    // Divider
    logic [31:0] quot;
    logic        div_last;

    bfd_div #(
        .SUMW (SUMW),
        .NPW  (NPW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_step     (i_cmd.div_step),
        .i_dividend (n_sum),
        .i_divisor  (r_npix),
        .o_quot     (quot),
        .o_last     (div_last)
    );

    // Output register
    logic r_ovalid;
    logic [bfd_pkg::PIX_W-1:0] r_odata;
    logic r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_odata <= quot;
            r_olast <= r_flast;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tlast  = r_olast;

    assign o_sts.active   = active;
    assign o_sts.blk_done = r_done;
    assign o_sts.div_last = div_last;
    assign o_sts.out_free = !r_ovalid || i_m_tready;

endmodule

// ===== hdl/bfd_ctrl.sv =====
// ----------------------------------------------------------------------------
// bfd_ctrl
// Sequencer: accept, accumulate, divide, hand to the output register.
// ----------------------------------------------------------------------------
module bfd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  bfd_pkg::t_sts i_sts,
    output bfd_pkg::t_cmd o_cmd
);

    bfd_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bfd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            bfd_pkg::ST_IDLE: begin
                o_s_tready   = 1'b1;
                o_cmd.accept = i_s_tvalid;
                if (i_s_tvalid && i_sts.active) begin
                    n_state = bfd_pkg::ST_ACC;
                end
            end
            bfd_pkg::ST_ACC: begin
                o_cmd.acc = 1'b1;
                if (i_sts.blk_done) begin
                    o_cmd.div_start = 1'b1;
                    n_state = bfd_pkg::ST_DIV;
                end else begin
                    n_state = bfd_pkg::ST_IDLE;
                end
            end
            bfd_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = bfd_pkg::ST_OUT;
                end
            end
            bfd_pkg::ST_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = bfd_pkg::ST_IDLE;
                end
            end
            default: n_state = bfd_pkg::ST_IDLE;
        endcase
    end

endmodule

// ===== hdl/box_filter_downscale.sv =====
// ----------------------------------------------------------------------------
// box_filter_downscale
// Box filter downscaler for a raster RGBA stream.
// ----------------------------------------------------------------------------
// Source pixels enter one at a time in raster order; each output pixel is the
// truncated per-channel mean of an h_scale by w_scale block, produced when the
// block's bottom right pixel arrives. A pixel outside the output area is only
// taken; a pixel that only adds to a column sum goes through a memory read,
// then add and write back; a pixel that closes a block also passes the
// bit-serial divider, one quotient bit per cycle for all four channels, and
// waits for a free output register. A finished result waits in the output
// register while the next pixel is taken. Any write to a known register
// restarts the frame position; column sums are not cleared and need none.
// ----------------------------------------------------------------------------
module box_filter_downscale #(
    parameter int MAX_DST_WIDTH = bfd_pkg::MAX_DST_WIDTH,
    parameter int MAX_SCALE     = bfd_pkg::MAX_SCALE,
    parameter int MAX_SRC_DIM   = bfd_pkg::MAX_SRC_DIM
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration write
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [bfd_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [bfd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // Source pixels
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [31:0]                    i_s_tdata,  // red_in, green_in, blue_in, alpha_in
    // Output pixels
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [31:0]                    o_m_tdata,  // red_out, green_out, blue_out, alpha_out
    output logic                           o_m_tlast   // frame_last
);

    bfd_pkg::t_cmd cmd;
    bfd_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    bfd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bfd_dpath #(
        .MAX_DST_WIDTH (MAX_DST_WIDTH),
        .MAX_SCALE     (MAX_SCALE),
        .MAX_SRC_DIM   (MAX_SRC_DIM)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_pix       (i_s_tdata),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

endmodule

// ===== bench/bfd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfd_checker
// Watches the box filter downscaler's channels, predicts and compares results.
// ----------------------------------------------------------------------------
// Keeps its own copy of the registers, the per-column channel sums and the
// frame position counters. Every source pixel transfer advances that copy and
// may queue one expected output pixel. Every output transfer is compared field
// by field against the oldest queued pixel.
// ----------------------------------------------------------------------------
module bfd_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [bfd_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [bfd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    input  logic [31:0]                    i_s_tdata,  // red, green, blue, alpha
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    input  logic [31:0]                    i_m_tdata,  // red, green, blue, alpha
    input  logic                           i_m_tlast,  // frame_last
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_results,
    output int                             o_frames
);

    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       last;
    } t_out_pix;

    // Register copy, masked to register widths
    logic [bfd_pkg::SRC_DIM_W-1:0] reg_src_w, reg_src_h;
    logic [bfd_pkg::DST_DIM_W-1:0] reg_dst_w, reg_dst_h;
    logic [bfd_pkg::SCALE_W-1:0]   reg_h_scale, reg_w_scale;

    // Running sums per output column and frame position
    int unsigned col_sum [bfd_pkg::MAX_DST_WIDTH][4];
    int unsigned src_col, src_row, blk_row, blk_col, out_col, out_row;

    t_out_pix avg_q[$];

    function automatic int unsigned eff_size(input int unsigned v, input int unsigned hi);
        int unsigned r;
        r = (v == 0) ? 1 : ((v > hi) ? hi : v);
        return r;
    endfunction

    task automatic restart_position();
        src_col = 0; src_row = 0; blk_row = 0; blk_col = 0; out_col = 0; out_row = 0;
    endtask

    task automatic apply_reg_write(input logic [bfd_pkg::CFG_IDX_W-1:0] idx,
                                   input logic [bfd_pkg::CFG_DATA_W-1:0] val);
        case (idx)
            bfd_pkg::CFG_SRC_WIDTH:  reg_src_w   = val[bfd_pkg::SRC_DIM_W-1:0];
            bfd_pkg::CFG_SRC_HEIGHT: reg_src_h   = val[bfd_pkg::SRC_DIM_W-1:0];
            bfd_pkg::CFG_DST_WIDTH:  reg_dst_w   = val[bfd_pkg::DST_DIM_W-1:0];
            bfd_pkg::CFG_DST_HEIGHT: reg_dst_h   = val[bfd_pkg::DST_DIM_W-1:0];
            bfd_pkg::CFG_H_SCALE:    reg_h_scale = val[bfd_pkg::SCALE_W-1:0];
            bfd_pkg::CFG_W_SCALE:    reg_w_scale = val[bfd_pkg::SCALE_W-1:0];
            default:                 return;     // unknown index: no effect at all
        endcase
        restart_position();
    endtask

    // Add one source pixel to its column sum; queue the mean when a block closes
    task automatic accumulate_pixel(input logic [31:0] pix);
        int unsigned sw, sh, dw, dh, hs, ws, npix, c;
        logic        first;
        t_out_pix    e;
        sw = eff_size(32'(reg_src_w), bfd_pkg::MAX_SRC_DIM);
        sh = eff_size(32'(reg_src_h), bfd_pkg::MAX_SRC_DIM);
        dw = eff_size(32'(reg_dst_w), bfd_pkg::MAX_DST_WIDTH);
        dh = eff_size(32'(reg_dst_h), bfd_pkg::DST_HEIGHT_MAX);
        hs = eff_size(32'(reg_h_scale), bfd_pkg::MAX_SCALE);
        ws = eff_size(32'(reg_w_scale), bfd_pkg::MAX_SCALE);
        if (out_col < dw && out_row < dh) begin
            first = (blk_row == 0) && (blk_col == 0);
            for (c = 0; c < 4; c++) begin
                col_sum[out_col][c] = first ? 32'(pix[8*c +: 8])
                                            : col_sum[out_col][c] + 32'(pix[8*c +: 8]);
            end
            if (blk_row + 1 >= hs && blk_col + 1 >= ws) begin
                npix    = hs * ws;
                e.red   = 8'(col_sum[out_col][0] / npix);
                e.green = 8'(col_sum[out_col][1] / npix);
                e.blue  = 8'(col_sum[out_col][2] / npix);
                e.alpha = 8'(col_sum[out_col][3] / npix);
                e.last  = (out_row + 1 == dh) && (out_col + 1 == dw);
                avg_q.push_back(e);
            end
        end
        // Advance the raster position
        blk_col++;
        if (blk_col >= ws) begin
            blk_col = 0;
            out_col++;
        end
        src_col++;
        if (src_col >= sw) begin
            src_col = 0; blk_col = 0; out_col = 0;
            blk_row++;
            if (blk_row >= hs) begin
                blk_row = 0;
                out_row++;
            end
            src_row++;
            if (src_row >= sh) restart_position();
        end
    endtask

    always @(posedge i_clk) begin
        t_out_pix e, got;
        if (!i_rst_n) begin
            reg_src_w <= bfd_pkg::SRC_DIM_W'(1); reg_src_h <= bfd_pkg::SRC_DIM_W'(1);
            reg_dst_w <= bfd_pkg::DST_DIM_W'(1); reg_dst_h <= bfd_pkg::DST_DIM_W'(1);
            reg_h_scale <= bfd_pkg::SCALE_W'(1); reg_w_scale <= bfd_pkg::SCALE_W'(1);
            restart_position();
            avg_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) apply_reg_write(i_cfg_addr, i_cfg_data);
            if (i_s_tvalid && i_s_tready) accumulate_pixel(i_s_tdata);
            // Output transfer against the oldest expected pixel
            if (i_m_tvalid && i_m_tready) begin
                got = {i_m_tdata, i_m_tlast};
                o_results++;
                if (i_m_tlast) o_frames++;
                if (avg_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("%0t: unexpected output pixel %h last %b",
                                 $realtime, i_m_tdata, i_m_tlast);
                end else begin
                    e = avg_q.pop_front();
                    if (got !== e) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("%0t: mismatch exp r%h g%h b%h a%h l%b %s",
                                     $realtime, e.red, e.green, e.blue, e.alpha, e.last,
                                     $sformatf("got r%h g%h b%h a%h l%b",
                                               got.red, got.green, got.blue,
                                               got.alpha, got.last));
                    end
                end
            end
        end
        o_pending <= avg_q.size();
    end

    initial begin
        o_fail_count = 0;
        o_results    = 0;
        o_frames     = 0;
        o_pending    = 0;
    end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the box filter downscaler.
// ----------------------------------------------------------------------------
// Runs directed frames (reset sizes, zero and oversized registers, full
// channel values, largest scales) and then random frame geometries with random
// pixels. Both stream sides idle at random; once the output side holds off
// for a long stretch so the block backs up. Checking is done in bfd_checker.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int N_ITEMS     = 1250;
    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE      = 60;    // covers the divider latency

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [bfd_pkg::CFG_IDX_W-1:0]  i_cfg_addr = '0;
    logic [bfd_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                           i_s_tvalid = 1'b0;
    logic                           o_s_tready;
    logic [31:0]                    i_s_tdata = '0;
    logic                           o_m_tvalid;
    logic                           i_m_tready = 1'b0;
    logic [31:0]                    o_m_tdata;
    logic                           o_m_tlast;

    int fail_count, pending, results, frames;
    int pixels_sent = 0;
    int cycles = 0;
    int phases = 0;
    logic held_off = 1'b0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    box_filter_downscale i_dut (.*);

    bfd_checker i_chk (
        .i_clk, .i_rst_n,
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_addr, .i_cfg_data,
        .i_s_tvalid, .i_s_tready(o_s_tready), .i_s_tdata,
        .i_m_tvalid(o_m_tvalid), .i_m_tready, .i_m_tdata(o_m_tdata), .i_m_tlast(o_m_tlast),
        .o_fail_count(fail_count), .o_pending(pending), .o_results(results), .o_frames(frames)
    );

    // No idling for a stretch in the middle of the run
    function automatic logic idle_roll();
        return !(pixels_sent >= 400 && pixels_sent < 600) && ($urandom_range(99) < 34);
    endfunction

    // Output side: random stalls, plus one long hold-off
    always @(posedge i_clk) begin
        int hold;
        if (!held_off && pixels_sent >= 800) begin
            held_off <= 1'b1;
            for (hold = 0; hold < 400; hold++) begin
                i_m_tready <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_m_tready <= i_rst_n && !idle_roll();
    end

    // Timeout
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    task automatic write_reg(input logic [bfd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bfd_pkg::CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_pixel(input logic [31:0] pix);
        while (idle_roll()) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= pix;
        do @(posedge i_clk); while (!o_s_tready);
        pixels_sent++;
    endtask

    // Let all expected results drain, then give the block time to go idle
    task automatic drain();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Program a frame geometry; sometimes also hit an unused index
    task automatic set_geometry(input int sw, input int sh, input int dw, input int dh,
                                input int hs, input int ws);
        drain();
        write_reg(bfd_pkg::CFG_SRC_WIDTH,  bfd_pkg::CFG_DATA_W'(sw));
        write_reg(bfd_pkg::CFG_SRC_HEIGHT, bfd_pkg::CFG_DATA_W'(sh));
        write_reg(bfd_pkg::CFG_DST_WIDTH,  bfd_pkg::CFG_DATA_W'(dw));
        write_reg(bfd_pkg::CFG_DST_HEIGHT, bfd_pkg::CFG_DATA_W'(dh));
        write_reg(bfd_pkg::CFG_H_SCALE,    bfd_pkg::CFG_DATA_W'(hs));
        write_reg(bfd_pkg::CFG_W_SCALE,    bfd_pkg::CFG_DATA_W'(ws));
        if ($urandom_range(3) == 0)
            write_reg(bfd_pkg::CFG_IDX_W'($urandom_range(6, 7)),
                      bfd_pkg::CFG_DATA_W'($urandom));
        phases++;
    endtask

    function automatic logic [31:0] rand_pixel();
        case ($urandom_range(5))
            0:       return 32'hFFFF_FFFF;
            1:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int i, sw, sh, dw, dh, hs, ws, n;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset geometry: every pixel is its own output
        send_pixel(32'h0000_0000);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h0123_4567);
        send_pixel(32'h8080_8080);
        // Zero registers act as one
        set_geometry(0, 0, 0, 0, 0, 0);
        send_pixel(32'hA5A5_5A5A);
        send_pixel(32'h5A5A_A5A5);
        // 2x2 blocks with cropped edge column and row, full channel values
        set_geometry(5, 5, 2, 2, 2, 2);
        for (i = 0; i < 25; i++) send_pixel(i[0] ? 32'hFFFF_FFFF : 32'hFEFF_FF01);
        // Largest scale, one output per frame
        set_geometry(16, 16, 1, 1, 16, 16);
        for (i = 0; i < 256; i++) send_pixel(32'hFFFF_FFFF);
        // Oversized scales clamp to the largest
        set_geometry(16, 16, 1, 1, 31, 31);
        for (i = 0; i < 256; i++) send_pixel(rand_pixel());
        // Oversized frame and output sizes; only a partial row is sent
        set_geometry(8191, 8191, 2047, 2047, 1, 1);
        for (i = 0; i < 40; i++) send_pixel(rand_pixel());
        set_geometry(4096, 2, 1024, 2047, 1, 4);
        for (i = 0; i < 30; i++) send_pixel(rand_pixel());

        // Random geometries, mostly consistent, a few with short sources
        while (pixels_sent < N_ITEMS) begin
            dw = $urandom_range(1, 6);
            dh = $urandom_range(1, 4);
            hs = $urandom_range(1, 4);
            ws = $urandom_range(1, 4);
            sw = dw * ws + $urandom_range(0, 2);
            sh = dh * hs + $urandom_range(0, 2);
            if ($urandom_range(9) == 0) sw = $urandom_range(1, sw);
            if ($urandom_range(9) == 0) sh = $urandom_range(1, sh);
            set_geometry(sw, sh, dw, dh, hs, ws);
            n = sw * sh * $urandom_range(1, 2) + $urandom_range(0, sw);
            for (i = 0; i < n && pixels_sent < N_ITEMS; i++) send_pixel(rand_pixel());
        end

        drain();
        $display("tb_top: %0d source pixels in %0d geometries, %0d output pixels, %0d frame ends",
                 pixels_sent, phases, results, frames);
        if (fail_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: %0d mismatches", fail_count);
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
